// ===== hw/rtl/i2c_master_bit_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// Property holds on every clock edge outside reset.
`define I2CMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent holds on the clock after the antecedent.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CMS_ASSERT(label, prop, msg)
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types, command codes and constants of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;
    // Half-bit ticks of one byte.
    localparam logic [4:0] LAST_PHASE = 5'(2 * BITS_PER_BYTE);
    localparam logic [7:0] POLL_MAX   = 8'hff;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'hff;

    // Command codes; code 7 is unused and behaves as a tick.
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_SEND_ACK = 3'd5,
        CMD_WAIT_ACK = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
    } out_item_t;

    typedef struct packed {
        logic [2:0] active_cmd;
        logic [4:0] phase_count;
        logic [7:0] shift_reg;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       sda_drive;
        logic       ack_flag;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        active_cmd:  CMD_TICK,
        phase_count: 5'd0,
        shift_reg:   8'h00,
        poll_count:  8'h00,
        scl:         1'b1,
        sda:         1'b1,
        sda_drive:   1'b1,
        ack_flag:    1'b0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/i2cms_step.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer step logic
// Computes the next sequencer state and the result beat for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step (
    input  wire i2cms_pkg::seq_state_t cur_state,
    input  wire i2cms_pkg::in_item_t   item,
    input  wire logic [7:0]            ack_timeout,
    output i2cms_pkg::seq_state_t      next_state,
    output i2cms_pkg::out_item_t       result
);

    logic done;

    // Next state: command launch, then one phase of the active command.
    always_comb
    begin
        i2cms_pkg::seq_state_t s;
        logic                  advance;
        s       = cur_state;
        done    = 1'b0;
        advance = 1'b1;

        if (s.active_cmd == i2cms_pkg::CMD_TICK &&
            item.cmd >= i2cms_pkg::CMD_START && item.cmd <= i2cms_pkg::CMD_WAIT_ACK)
        begin
            s.active_cmd  = item.cmd;
            s.phase_count = 5'd0;
            if (item.cmd == i2cms_pkg::CMD_WRITE)
            begin
                s.shift_reg = item.tx_byte;
            end
            if (item.cmd == i2cms_pkg::CMD_READ)
            begin
                s.shift_reg = 8'h00;
            end
            if (item.cmd == i2cms_pkg::CMD_WAIT_ACK)
            begin
                s.ack_flag   = 1'b0;
                s.poll_count = 8'h00;
            end
        end

        case (s.active_cmd)
            i2cms_pkg::CMD_START:
            begin
                if (s.phase_count == 5'd0)
                begin
                    s.sda_drive = 1'b1;
                    s.sda       = 1'b1;
                    s.scl       = 1'b1;
                end
                else if (s.phase_count == 5'd1)
                begin
                    s.sda = 1'b0;
                end
                else
                begin
                    s.scl   = 1'b0;
                    done    = 1'b1;
                    advance = 1'b0;
                end
            end
            i2cms_pkg::CMD_STOP:
            begin
                if (s.phase_count == 5'd0)
                begin
                    s.sda_drive = 1'b1;
                    s.sda       = 1'b0;
                    s.scl       = 1'b1;
                end
                else
                begin
                    s.sda   = 1'b1;
                    done    = 1'b1;
                    advance = 1'b0;
                end
            end
            i2cms_pkg::CMD_WRITE:
            begin
                if (s.phase_count < i2cms_pkg::LAST_PHASE)
                begin
                    if (!s.phase_count[0])
                    begin
                        s.scl       = 1'b0;
                        s.sda_drive = 1'b1;
                        s.sda       = s.shift_reg[7];
                        s.shift_reg = {s.shift_reg[6:0], 1'b0};
                    end
                    else
                    begin
                        s.scl = 1'b1;
                    end
                end
                else
                begin
                    s.scl   = 1'b0;
                    done    = 1'b1;
                    advance = 1'b0;
                end
            end
            i2cms_pkg::CMD_READ:
            begin
                if (s.phase_count == 5'd0)
                begin
                    s.sda       = 1'b1;
                    s.sda_drive = 1'b0;
                end
                if (!s.phase_count[0])
                begin
                    // Sample SDA as SCL rises.
                    s.scl       = 1'b1;
                    s.shift_reg = {s.shift_reg[6:0], item.sda_in};
                end
                else
                begin
                    s.scl = 1'b0;
                    if (s.phase_count >= i2cms_pkg::LAST_PHASE - 5'd1)
                    begin
                        s.sda_drive = 1'b1;
                        done        = 1'b1;
                        advance     = 1'b0;
                    end
                end
            end
            i2cms_pkg::CMD_SEND_ACK:
            begin
                if (s.phase_count == 5'd0)
                begin
                    s.sda_drive = 1'b1;
                    s.sda       = item.ack_level;
                    s.scl       = 1'b1;
                end
                else
                begin
                    s.scl   = 1'b0;
                    done    = 1'b1;
                    advance = 1'b0;
                end
            end
            i2cms_pkg::CMD_WAIT_ACK:
            begin
                if (s.phase_count == 5'd0)
                begin
                    s.sda_drive = 1'b0;
                end
                else if (s.phase_count == 5'd1)
                begin
                    s.scl = 1'b1;
                end
                else if (s.phase_count == 5'd2)
                begin
                    advance = 1'b0;
                    if (!item.sda_in)
                    begin
                        s.scl       = 1'b0;
                        s.sda_drive = 1'b1;
                        s.ack_flag  = 1'b1;
                        done        = 1'b1;
                    end
                    else
                    begin
                        // Saturating poll count; on timeout begin a stop.
                        if (s.poll_count < i2cms_pkg::POLL_MAX)
                        begin
                            s.poll_count = s.poll_count + 8'd1;
                        end
                        if (s.poll_count >= ack_timeout)
                        begin
                            s.sda_drive   = 1'b1;
                            s.sda         = 1'b0;
                            s.scl         = 1'b1;
                            s.phase_count = 5'd3;
                        end
                    end
                end
                else
                begin
                    s.sda      = 1'b1;
                    s.ack_flag = 1'b0;
                    done       = 1'b1;
                    advance    = 1'b0;
                end
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase

        if (done)
        begin
            s.active_cmd  = i2cms_pkg::CMD_TICK;
            s.phase_count = 5'd0;
        end
        if (advance)
        begin
            s.phase_count = s.phase_count + 5'd1;
        end
        next_state = s;
    end

    // Result beat taken from the updated state.
    always_comb
    begin
        result.scl_level = next_state.scl;
        result.sda_level = next_state.sda;
        result.sda_drive = next_state.sda_drive;
        result.busy_res  = (next_state.active_cmd != i2cms_pkg::CMD_TICK);
        result.done_res  = done;
        result.rx_byte   = next_state.shift_reg;
        result.ack_ok    = next_state.ack_flag;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Half-bit tick sequencer for START, STOP, byte write/read and ack handling.
// ----------------------------------------------------------------------------
// Usage: every input beat (in_valid/in_stall, payload in_item) is one half-bit
// tick of the bus, carrying a command, the byte to write, the ack bit to send
// and the sampled SDA level. Each input beat yields exactly one result beat
// (out_valid/out_stall, payload out_item) with the SCL/SDA line state, busy,
// done, the shift register contents and the ack result.
// An accepted tick is first held in the input register, and the step logic
// feeds the result register; out_valid rises as the tick moves into it.
// Throughput is one beat per cycle while out_stall is low; the sequencer state
// updates as a tick moves into the result register.
// The ack_timeout register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while no command is in progress.
// Reset clears both registers' valid flags, returns the sequencer to idle
// with SCL and SDA released high and SDA driven, and sets ack_timeout to 255.
// When the receiver stalls, the result beat holds; the input register keeps
// one tick and in_stall is high while both stages are full and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire i2cms_pkg::in_item_t  in_item,
    output logic                      out_valid,
    input  wire                       out_stall,
    output i2cms_pkg::out_item_t      out_item,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_data
);

    logic                  in_valid_reg;
    i2cms_pkg::in_item_t   in_item_reg;
    logic                  out_valid_reg;
    i2cms_pkg::out_item_t  out_item_reg;
    i2cms_pkg::seq_state_t state_reg;
    i2cms_pkg::seq_state_t state_next;
    i2cms_pkg::out_item_t  step_out;
    logic [7:0]            ack_timeout_reg;
    logic                  advance;
    logic                  in_accept;

    // Handshake control between the two stages.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    i2cms_step u_step (
        .cur_state   (state_reg),
        .item        (in_item_reg),
        .ack_timeout (ack_timeout_reg),
        .next_state  (state_next),
        .result      (step_out)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item;
        end
    end

    // Sequencer state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2cms_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_out;
        end
    end

    // Ack timeout configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= i2cms_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ack_timeout_reg <= cfg_data;
        end
    end

    // Checks on the stage control and the sequencer state.
    `I2CMS_ASSERT_NEXT(a_done_goes_idle, advance && step_out.done_res, state_reg.active_cmd == i2cms_pkg::CMD_TICK, "sequencer not idle after done")
    `I2CMS_ASSERT_NEXT(a_state_holds, !advance, $stable(state_reg), "state changed without a tick")
    `I2CMS_ASSERT(a_stall_needs_item, !in_stall || (in_valid_reg && out_valid_reg), "input stalled with a free stage")
    `I2CMS_ASSERT(a_phase_bound, state_reg.phase_count <= i2cms_pkg::LAST_PHASE, "phase count beyond one byte")

endmodule

`default_nettype wire
